@@ hdl/hrfd_pkg.sv @@
// Package with shared types, character codes and helpers for the hex record framer.
`default_nettype none

package hrfd_pkg;

    localparam int unsigned MAX_FRAME = 43;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_A     = 8'h41;

    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd5000;
    localparam logic [9:0]  FRAME_OVERHEAD   = 10'd11;
    localparam logic [5:0]  POS_MAX          = 6'd63;

    typedef enum logic [1:0] {
        REQ_POLL    = 2'd0,
        REQ_BYTE    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // Non-hex characters decode as zero.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/hex_record_frame_detector_unit.sv @@
// The result of an accepted word is written into the output register at the accepting edge.
// Throughput: one word per cycle; a word is taken whenever the output register is
// empty or its result is being taken in the same cycle.
// The framing state is updated at the accepting edge, so consecutive words chain.
// Reset is synchronous, active low: framing state clears and the idle limit loads 5000.
// The output register holds its result while the output side stalls.
`default_nettype none

module hex_record_frame_detector_unit
    import hrfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [5:0]       o_byte_position,
    output logic [7:0]       o_byte_value,
    output logic             o_byte_accepted,
    output logic             o_frame_complete,
    output logic             o_timed_out
);

    logic [15:0] r_idle_limit;
    logic [5:0]  r_rx_position;
    logic        r_frame_rejected;
    logic [3:0]  r_high_nibble;
    logic [7:0]  r_record_length;
    logic [15:0] r_idle_count;
    logic        r_done_flag;
    logic        r_colon_start;

    logic        r_out_valid;
    logic [5:0]  r_byte_position;
    logic [7:0]  r_byte_value;
    logic        r_byte_accepted;
    logic        r_frame_complete;
    logic        r_timed_out;

    logic [5:0]  n_rx_position;
    logic        n_frame_rejected;
    logic [3:0]  n_high_nibble;
    logic [7:0]  n_record_length;
    logic [15:0] n_idle_count;
    logic        n_done_flag;
    logic        n_colon_start;
    logic [5:0]  n_byte_position;
    logic [7:0]  n_byte_value;
    logic        n_byte_accepted;
    logic        n_timed_out;
    logic [9:0]  frame_len;

    logic        in_accept;
    logic        out_take;
    t_req        req;

    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign req        = t_req'(i_req_type);

    always_comb begin
        n_rx_position    = r_rx_position;
        n_frame_rejected = r_frame_rejected;
        n_high_nibble    = r_high_nibble;
        n_record_length  = r_record_length;
        n_idle_count     = r_idle_count;
        n_done_flag      = r_done_flag;
        n_colon_start    = r_colon_start;
        n_byte_position  = r_rx_position;
        n_byte_value     = 8'd0;
        n_byte_accepted  = 1'b0;
        n_timed_out      = 1'b0;
        frame_len        = {1'b0, n_record_length, 1'b0} + FRAME_OVERHEAD;

        unique case (req)
            REQ_POLL: begin
                if (r_idle_count != 16'hFFFF) begin
                    n_idle_count = r_idle_count + 16'd1;
                end
                if (n_idle_count > r_idle_limit) begin
                    n_rx_position    = 6'd0;
                    n_frame_rejected = 1'b0;
                    n_timed_out      = 1'b1;
                end
                n_byte_position = n_rx_position;
            end
            REQ_BYTE: begin
                n_idle_count = 16'd0;
                n_byte_value = i_rx_byte;
                if (!r_frame_rejected && r_rx_position < 6'(MAX_FRAME)) begin
                    n_byte_accepted = 1'b1;
                    if (r_rx_position == 6'd0) begin
                        if (i_rx_byte == CHAR_COLON || i_rx_byte == CHAR_SEMI ||
                            i_rx_byte == CHAR_A) begin
                            n_colon_start = (i_rx_byte == CHAR_COLON);
                        end else begin
                            n_frame_rejected = 1'b1;
                            n_byte_accepted  = 1'b0;
                        end
                    end else if (r_rx_position == 6'd1) begin
                        n_high_nibble = hex_digit(i_rx_byte);
                    end else if (r_rx_position == 6'd2) begin
                        if (r_colon_start) begin
                            n_record_length = {r_high_nibble, hex_digit(i_rx_byte)};
                        end
                    end
                end
                n_rx_position = (r_rx_position < POS_MAX) ? r_rx_position + 6'd1 : POS_MAX;
                // Length compare uses the length decoded by this very byte.
                frame_len = {1'b0, n_record_length, 1'b0} + FRAME_OVERHEAD;
                if (n_byte_accepted && {4'd0, n_rx_position} == frame_len) begin
                    n_done_flag = 1'b1;
                end
            end
            REQ_RESTART: begin
                n_rx_position    = 6'd0;
                n_frame_rejected = 1'b0;
                n_done_flag      = 1'b0;
                n_byte_position  = 6'd0;
            end
            REQ_NONE: begin
                n_byte_position = r_rx_position;
            end
            default: begin
                n_byte_position = r_rx_position;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit     <= IDLE_LIMIT_RESET;
            r_rx_position    <= 6'd0;
            r_frame_rejected <= 1'b0;
            r_high_nibble    <= 4'd0;
            r_record_length  <= 8'd0;
            r_idle_count     <= 16'd0;
            r_done_flag      <= 1'b0;
            r_colon_start    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_rx_position    <= n_rx_position;
                r_frame_rejected <= n_frame_rejected;
                r_high_nibble    <= n_high_nibble;
                r_record_length  <= n_record_length;
                r_idle_count     <= n_idle_count;
                r_done_flag      <= n_done_flag;
                r_colon_start    <= n_colon_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte_position  <= n_byte_position;
            r_byte_value     <= n_byte_value;
            r_byte_accepted  <= n_byte_accepted;
            r_frame_complete <= n_done_flag;
            r_timed_out      <= n_timed_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_position  = r_byte_position;
    assign o_byte_value     = r_byte_value;
    assign o_byte_accepted  = r_byte_accepted;
    assign o_frame_complete = r_frame_complete;
    assign o_timed_out      = r_timed_out;

    // A timeout always leaves the frame at its start.
    a_timeout_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timed_out) |-> (o_byte_position == 6'd0))
        else $error("timeout result with nonzero position");

    // Only bytes inside the maximum frame length can be accepted.
    a_accept_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_accepted) |-> (o_byte_position < 6'(MAX_FRAME)))
        else $error("accepted byte beyond maximum frame length");

    // A restart clears the position and the completion flag.
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && req == REQ_RESTART) |=>
            (r_rx_position == 6'd0 && !r_done_flag && !o_frame_complete))
        else $error("restart did not clear framing state");

    // A word is only taken when the output register can hold its result.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !in_accept)
        else $error("word accepted while result is stalled");

endmodule

`default_nettype wire
